[rtl/dmc_pkg.sv]
// Shared constants and types for the direct-mapped cache.
`timescale 1ns / 1ps
package dmc_pkg;

  localparam int ADDR_W     = 12;
  localparam int DATA_W     = 8;
  localparam int CNT_W      = 32;
  localparam int LINE_BYTES = 16;
  localparam int NUM_LINES  = 8;
  localparam int MEM_BYTES  = 4096;
  localparam int OFS_W      = $clog2(LINE_BYTES);
  localparam int LINE_W     = $clog2(NUM_LINES);
  localparam int TAG_W      = ADDR_W - OFS_W - LINE_W;
  localparam int MEM_AW     = $clog2(MEM_BYTES);
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HIT_CYCLES   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_PENALTY = CFG_IDX_W'(1);

  localparam logic [DATA_W-1:0] HIT_CYCLES_RST   = 8'd1;
  localparam logic [DATA_W-1:0] MISS_PENALTY_RST = 8'd20;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_ACCESS = 1'b1
  } req_kind_t;

  // Command into the line store (tag memory, valid bits, line data memory)
  typedef struct packed {
    logic              tag_rd_en;
    logic              tag_wr_en;
    logic              data_rd_en;
    logic              data_wr_en;
    logic [LINE_W-1:0] line;
    logic [OFS_W-1:0]  ofs;
    logic [TAG_W-1:0]  tag;
    logic [DATA_W-1:0] wr_byte;
  } line_cmd_t;

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [DATA_W-1:0] rd_byte;
  } line_rsp_t;

  // Single port of the backing memory
  typedef struct packed {
    logic              en;
    logic              we;
    logic [MEM_AW-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_cmd_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_data;
    logic [CNT_W-1:0]  access_count;
    logic [CNT_W-1:0]  miss_count;
    logic [CNT_W-1:0]  elapsed_time;
  } result_t;

endpackage

[rtl/dmc_backing_mem.sv]
// Single-port backing memory with registered read data.
`timescale 1ns / 1ps
module dmc_backing_mem
  import dmc_pkg::*;
(
  input  logic              clk,
  input  mem_cmd_t          cmd,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [MEM_BYTES];

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      if (cmd.we) begin
        mem[cmd.addr] <= cmd.wdata;
      end else begin
        rdata <= mem[cmd.addr];
      end
    end
  end

endmodule

[rtl/dmc_line_store.sv]
// Cache line store: tag memory, per-line valid bits and line data memory.
`timescale 1ns / 1ps
module dmc_line_store
  import dmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  line_cmd_t cmd,
  output line_rsp_t rsp
);

  logic [NUM_LINES-1:0] valid_bits;
  logic [TAG_W-1:0]     tag_mem  [NUM_LINES];
  logic [DATA_W-1:0]    data_mem [NUM_LINES * LINE_BYTES];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (cmd.tag_wr_en) begin
      valid_bits[cmd.line] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tag_wr_en) begin
      tag_mem[cmd.line] <= cmd.tag;
    end
    if (cmd.data_wr_en) begin
      data_mem[{cmd.line, cmd.ofs}] <= cmd.wr_byte;
    end
    if (cmd.tag_rd_en) begin
      rsp.valid <= valid_bits[cmd.line];
      rsp.tag   <= tag_mem[cmd.line];
    end
    if (cmd.data_rd_en) begin
      rsp.rd_byte <= data_mem[{cmd.line, cmd.ofs}];
    end
  end

endmodule

[rtl/dmc_ctrl.sv]
// Request sequencer: lookup, line fill, and saturating statistics counters.
`timescale 1ns / 1ps
module dmc_ctrl
  import dmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic              req_kind,
  input  logic [ADDR_W-1:0] req_addr_in,
  input  logic [DATA_W-1:0] req_wdata,
  input  logic [DATA_W-1:0] hit_cycles,
  input  logic [DATA_W-1:0] miss_penalty,
  output line_cmd_t         line_cmd,
  input  line_rsp_t         line_rsp,
  output mem_cmd_t          mem_cmd,
  input  logic [DATA_W-1:0] mem_rdata,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_FILL,
    S_RESP
  } state_t;

  state_t             state;
  logic [ADDR_W-1:0]  req_addr;
  logic               is_access;
  logic               hit_q;
  logic [DATA_W-1:0]  rdata_q;
  logic [OFS_W-1:0]   fcnt;
  logic [CNT_W-1:0]   acc_total;
  logic [CNT_W-1:0]   miss_total;
  logic [CNT_W-1:0]   time_total;

  logic [CNT_W-1:0]   acc_next;
  logic [CNT_W-1:0]   miss_next;
  logic [CNT_W-1:0]   time_next;
  logic [CNT_W:0]     acc_sum;
  logic [CNT_W:0]     miss_sum;
  logic [CNT_W+1:0]   time_sum;

  logic [TAG_W-1:0]   req_tag;
  logic [LINE_W-1:0]  req_line;
  logic [OFS_W-1:0]   req_ofs;
  logic               hit_now;
  logic               accept;
  logic               fill_last;
  logic               fire;
  logic               res_hit;

  assign req_tag   = req_addr[ADDR_W-1 -: TAG_W];
  assign req_line  = req_addr[OFS_W +: LINE_W];
  assign req_ofs   = req_addr[OFS_W-1:0];
  assign hit_now   = line_rsp.valid && (line_rsp.tag == req_tag);
  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign fill_last = (fcnt == OFS_W'(LINE_BYTES - 1));
  assign res_valid = ((state == S_LOOKUP) && hit_now) || (state == S_RESP);
  assign fire      = res_valid && res_ready;
  assign res_hit   = (state == S_LOOKUP) ? 1'b1 : hit_q;

  // Saturating statistics; the sum of two adds saturates the same as two steps.
  always_comb begin
    acc_sum  = {1'b0, acc_total} + (CNT_W + 1)'(1);
    miss_sum = {1'b0, miss_total} + (CNT_W + 1)'(1);
    time_sum = {2'b00, time_total} + (CNT_W + 2)'(hit_cycles)
             + (res_hit ? (CNT_W + 2)'(0) : (CNT_W + 2)'(miss_penalty));
    acc_next  = acc_total;
    miss_next = miss_total;
    time_next = time_total;
    if (is_access) begin
      acc_next  = acc_sum[CNT_W] ? '1 : acc_sum[CNT_W-1:0];
      time_next = (time_sum[CNT_W+1:CNT_W] != 2'b00) ? '1 : time_sum[CNT_W-1:0];
      if (!res_hit) begin
        miss_next = miss_sum[CNT_W] ? '1 : miss_sum[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    res.hit          = res_hit;
    res.read_data    = (state == S_LOOKUP) ? line_rsp.rd_byte : rdata_q;
    res.access_count = acc_next;
    res.miss_count   = miss_next;
    res.elapsed_time = time_next;
  end

  always_comb begin
    line_cmd = '0;
    mem_cmd  = '0;
    case (state)
      S_IDLE: begin
        line_cmd.tag_rd_en  = accept && (req_kind == REQ_ACCESS);
        line_cmd.data_rd_en = accept && (req_kind == REQ_ACCESS);
        line_cmd.line       = req_addr_in[OFS_W +: LINE_W];
        line_cmd.ofs        = req_addr_in[OFS_W-1:0];
        mem_cmd.en          = accept && (req_kind == REQ_LOAD);
        mem_cmd.we          = 1'b1;
        mem_cmd.addr        = req_addr_in[MEM_AW-1:0];
        mem_cmd.wdata       = req_wdata;
      end
      S_LOOKUP: begin
        // fetch the first byte of the block on a miss
        mem_cmd.en   = !hit_now;
        mem_cmd.addr = {req_tag, req_line, OFS_W'(0)};
      end
      S_FILL: begin
        line_cmd.data_wr_en = 1'b1;
        line_cmd.tag_wr_en  = fill_last;
        line_cmd.line       = req_line;
        line_cmd.ofs        = fcnt;
        line_cmd.tag        = req_tag;
        line_cmd.wr_byte    = mem_rdata;
        mem_cmd.en          = !fill_last;
        mem_cmd.addr        = {req_tag, req_line, fcnt + OFS_W'(1)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      acc_total  <= '0;
      miss_total <= '0;
      time_total <= '0;
    end else begin
      if (fire) begin
        acc_total  <= acc_next;
        miss_total <= miss_next;
        time_total <= time_next;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            req_addr  <= req_addr_in;
            is_access <= (req_kind == REQ_ACCESS);
            hit_q     <= 1'b0;
            rdata_q   <= '0;
            state     <= (req_kind == REQ_ACCESS) ? S_LOOKUP : S_RESP;
          end
        end
        S_LOOKUP: begin
          if (hit_now) begin
            hit_q   <= 1'b1;
            rdata_q <= line_rsp.rd_byte;
            state   <= res_ready ? S_IDLE : S_RESP;
          end else begin
            fcnt  <= '0;
            state <= S_FILL;
          end
        end
        S_FILL: begin
          if (fcnt == req_ofs) begin
            rdata_q <= mem_rdata;
          end
          if (fill_last) begin
            state <= S_RESP;
          end else begin
            fcnt <= fcnt + OFS_W'(1);
          end
        end
        S_RESP: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_miss_le_access: assert property (@(posedge clk) disable iff (rst)
    miss_total <= acc_total)
    else $error("miss count exceeds access count");

  a_time_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> time_total >= $past(time_total))
    else $error("elapsed time decreased");

  a_fill_from_lookup: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) && ($past(state) != S_FILL) |-> $past(state) == S_LOOKUP)
    else $error("line fill started outside a lookup");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP) && !res_ready |=> (state == S_RESP) && $stable(res))
    else $error("pending result dropped or changed");

endmodule

[rtl/direct_mapped_cache.sv]
// Direct-mapped cache top level: config registers, output register, submodules.
`timescale 1ns / 1ps
// Eight lines of sixteen bytes in front of a 4 KiB backing memory; address bits
// 11..7 are the tag, 6..4 the line and 3..0 the byte offset. One transaction is
// handled at a time. A load (tuser 0) or a hit needs no refill; on a miss the
// line is refilled one byte per cycle through the single port of the backing
// memory. Every transaction returns exactly one result; a result waits in an
// output register, and the next transaction is accepted while it waits. The
// valid bits of the lines clear at reset, so no clearing pass is needed.
// Reading a backing byte that was never loaded returns an undefined value.
module direct_mapped_cache
  import dmc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,   // addr[11:0], write_data[19:12], zero pad
  input  logic                 s_tuser,   // req_type
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [103:0]         m_tdata,   // read_data, access_count, miss_count,
                                          // elapsed_time
  output logic                 m_tuser,   // hit
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  logic [DATA_W-1:0] hit_cycles;
  logic [DATA_W-1:0] miss_penalty;
  line_cmd_t         line_cmd;
  line_rsp_t         line_rsp;
  mem_cmd_t          mem_cmd;
  logic [DATA_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_ready;
  result_t           res;
  result_t           out_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cycles   <= HIT_CYCLES_RST;
      miss_penalty <= MISS_PENALTY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HIT_CYCLES:   hit_cycles   <= cfg_data;
        CFG_MISS_PENALTY: miss_penalty <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Output register: load when empty or draining this cycle.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_tuser = out_q.hit;
  assign m_tdata = {out_q.elapsed_time, out_q.miss_count, out_q.access_count,
                    out_q.read_data};

  dmc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (s_tvalid),
    .req_ready    (s_tready),
    .req_kind     (s_tuser),
    .req_addr_in  (s_tdata[ADDR_W-1:0]),
    .req_wdata    (s_tdata[ADDR_W +: DATA_W]),
    .hit_cycles   (hit_cycles),
    .miss_penalty (miss_penalty),
    .line_cmd     (line_cmd),
    .line_rsp     (line_rsp),
    .mem_cmd      (mem_cmd),
    .mem_rdata    (mem_rdata),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  dmc_line_store u_lines (
    .clk (clk),
    .rst (rst),
    .cmd (line_cmd),
    .rsp (line_rsp)
  );

  dmc_backing_mem u_mem (
    .clk   (clk),
    .cmd   (mem_cmd),
    .rdata (mem_rdata)
  );

endmodule
